### rtl/core/pt_pkg.sv
// Shared types, constants and elaboration-time helpers for the potential
// temperature pipeline. No dependencies.
package pt_pkg;

   localparam int Stages = 16;
   localparam logic [15:0] KelvinOffset = 16'd17482;
   localparam logic [15:0] KappaReset = 16'd18736;
   localparam logic [17:0] ThetaMax = 18'h3FFFF;
   localparam logic KappaIndex = 1'b0;

   typedef struct packed {
      logic [15:0] tk;
      logic        miss;
      logic        last;
   } pt_side_type;

   function automatic logic [19:0] log2q_const(input logic [15:0] x);
      logic [63:0] m;
      logic [15:0] frac;
      int e;
      e = 0;
      for (int i = 0; i < 16; i++) begin
         if (x[i]) e = i;
      end
      m = 64'(x) << (30 - e);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = {frac[14:0], 1'b0};
         if (m[31]) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {4'(e), frac};
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v = x;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
      end
      return res;
   endfunction

   // root of 2 taken k+1 times, Q1.30
   function automatic logic [30:0] exp_root(input int k);
      logic [63:0] c;
      c = 64'h8000_0000;
      for (int i = 0; i <= k; i++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

   localparam logic [19:0] LogRef = log2q_const(16'd16000);

endpackage

### rtl/core/pt_log2.sv
// Sixteen-stage log2 pipeline: one mantissa squaring per stage, one fraction
// bit out of each. Depends on pt_pkg.
module pt_log2 (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  pt_pkg::pt_side_type in_side,
   input  logic [3:0]          in_e,
   input  logic [30:0]         in_m,
   output logic                out_valid,
   output pt_pkg::pt_side_type out_side,
   output logic [19:0]         out_log
);

   logic                valid_ff [pt_pkg::Stages];
   pt_pkg::pt_side_type side_ff  [pt_pkg::Stages];
   logic [3:0]          e_ff     [pt_pkg::Stages];
   logic [30:0]         m_ff     [pt_pkg::Stages];
   logic [15:0]         frac_ff  [pt_pkg::Stages];
   logic [30:0]         m_in     [pt_pkg::Stages];
   logic [15:0]         frac_in  [pt_pkg::Stages];

   for (genvar k = 0; k < pt_pkg::Stages; k++) begin : g_stage
      logic                vs;
      pt_pkg::pt_side_type ss;
      logic [3:0]          es;
      logic [30:0]         ms;
      logic [15:0]         fs;
      logic [61:0]         sq;
      if (k == 0) begin : g_first
         assign vs = in_valid;
         assign ss = in_side;
         assign es = in_e;
         assign ms = in_m;
         assign fs = '0;
      end else begin : g_next
         assign vs = valid_ff[k-1];
         assign ss = side_ff[k-1];
         assign es = e_ff[k-1];
         assign ms = m_ff[k-1];
         assign fs = frac_ff[k-1];
      end
      assign sq = ms * ms;
      assign m_in[k] = sq[61] ? sq[61:31] : sq[60:30];
      assign frac_in[k] = {fs[14:0], sq[61]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= ss;
            e_ff[k]    <= es;
            m_ff[k]    <= m_in[k];
            frac_ff[k] <= frac_in[k];
         end
      end
   end

   assign out_valid = valid_ff[pt_pkg::Stages-1];
   assign out_side  = side_ff[pt_pkg::Stages-1];
   assign out_log   = {e_ff[pt_pkg::Stages-1], frac_ff[pt_pkg::Stages-1]};

endmodule

### rtl/core/pt_exp2.sv
// Sixteen-stage exp2 pipeline: one conditional multiply by a fixed root of
// two per fraction bit, msb first. Depends on pt_pkg.
module pt_exp2 (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  pt_pkg::pt_side_type in_side,
   input  logic [15:0]         in_f,
   input  logic [5:0]          in_s,
   output logic                out_valid,
   output pt_pkg::pt_side_type out_side,
   output logic [30:0]         out_r,
   output logic [5:0]          out_s
);

   logic                valid_ff [pt_pkg::Stages];
   pt_pkg::pt_side_type side_ff  [pt_pkg::Stages];
   logic [15:0]         f_ff     [pt_pkg::Stages];
   logic [5:0]          s_ff     [pt_pkg::Stages];
   logic [30:0]         r_ff     [pt_pkg::Stages];
   logic [30:0]         r_in     [pt_pkg::Stages];

   for (genvar k = 0; k < pt_pkg::Stages; k++) begin : g_stage
      localparam logic [30:0] Root = pt_pkg::exp_root(k);
      logic                vs;
      pt_pkg::pt_side_type ss;
      logic [15:0]         fs;
      logic [5:0]          s_src;
      logic [30:0]         rs;
      logic [61:0]         pr;
      if (k == 0) begin : g_first
         assign vs    = in_valid;
         assign ss    = in_side;
         assign fs    = in_f;
         assign s_src = in_s;
         assign rs    = 31'h4000_0000;
      end else begin : g_next
         assign vs    = valid_ff[k-1];
         assign ss    = side_ff[k-1];
         assign fs    = f_ff[k-1];
         assign s_src = s_ff[k-1];
         assign rs    = r_ff[k-1];
      end
      assign pr = rs * Root;
      assign r_in[k] = fs[pt_pkg::Stages-1-k] ? pr[60:30] : rs;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= ss;
            f_ff[k]    <= fs;
            s_ff[k]    <= s_src;
            r_ff[k]    <= r_in[k];
         end
      end
   end

   assign out_valid = valid_ff[pt_pkg::Stages-1];
   assign out_side  = side_ff[pt_pkg::Stages-1];
   assign out_r     = r_ff[pt_pkg::Stages-1];
   assign out_s     = s_ff[pt_pkg::Stages-1];

endmodule

### rtl/core/potential_temperature_unit.sv
// Potential temperature unit: input register, log2 pipeline, scaling registers, exp2 pipeline,
// product register and output register lie between request and result. Throughput one request
// per cycle; the whole pipeline freezes while the output register holds a stalled result.
// Synchronous active-high reset clears all valid bits and sets kappa to 18736.
// Depends on pt_pkg, pt_log2, pt_exp2.
module potential_temperature_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_temp_celsius,
   input  logic               req_temp_missing,
   input  logic [15:0]        req_pressure_mb,
   input  logic               req_pres_missing,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [17:0]        rsp_theta_kelvin,
   output logic               rsp_result_missing,
   output logic               rsp_last_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic en;
   logic [15:0] kappa_ff;

   // input stage
   logic                v0_ff;
   pt_pkg::pt_side_type side0_ff, side0_in;
   logic [3:0]          e0_ff, e0_in;
   logic [30:0]         m0_ff, m0_in;

   logic                lg_valid;
   pt_pkg::pt_side_type lg_side;
   logic [19:0]         lg_log;

   logic                vl_ff;
   pt_pkg::pt_side_type sidel_ff;
   logic signed [21:0]  l_ff, l_in;

   logic                vp_ff;
   pt_pkg::pt_side_type sidep_ff;
   logic signed [38:0]  prod_ff, prod_in;

   logic                ve_ff;
   pt_pkg::pt_side_type sidee_ff;
   logic [15:0]         f_ff, f_in;
   logic [5:0]          s_ff, s_in;
   logic signed [38:0]  rnd_e;
   logic signed [7:0]   s_full;

   logic                ex_valid;
   pt_pkg::pt_side_type ex_side;
   logic [30:0]         ex_r;
   logic [5:0]          ex_s;

   logic                va_ff;
   pt_pkg::pt_side_type sidea_ff;
   logic [46:0]         acc_ff, acc_in;
   logic [5:0]          sa_ff;

   logic                rsp_valid_ff;
   logic [17:0]         theta_ff, theta_in;
   logic                miss_ff;
   logic                last_ff;
   logic [47:0]         rnd;
   logic [47:0]         shifted;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == pt_pkg::KappaIndex) ? {16'd0, kappa_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         kappa_ff <= pt_pkg::KappaReset;
      end else if (psel && penable && pwrite && paddr[2] == pt_pkg::KappaIndex) begin
         kappa_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      side0_in.tk   = {req_temp_celsius[14], req_temp_celsius} + pt_pkg::KelvinOffset;
      side0_in.miss = req_temp_missing || req_pres_missing || (req_pressure_mb == 16'd0);
      side0_in.last = req_last_point;
      e0_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_pressure_mb[i]) e0_in = 4'(i);
      end
      m0_in = 31'(req_pressure_mb) << (5'd30 - {1'b0, e0_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff <= side0_in;
         e0_ff    <= e0_in;
         m0_ff    <= m0_in;
      end
   end

   pt_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_side   (side0_ff),
      .in_e      (e0_ff),
      .in_m      (m0_ff),
      .out_valid (lg_valid),
      .out_side  (lg_side),
      .out_log   (lg_log)
   );

   assign l_in    = $signed({2'b00, pt_pkg::LogRef}) - $signed({2'b00, lg_log});
   assign prod_in = 39'(l_ff) * $signed({23'd0, kappa_ff});
   assign rnd_e   = prod_ff + 39'sd32768;
   assign f_in    = rnd_e[31:16];
   assign s_full  = 8'sd30 - $signed(rnd_e[38:32]);

   always_comb begin
      if (s_full < 8'sd1) begin
         s_in = 6'd1;
      end else if (s_full > 8'sd62) begin
         s_in = 6'd62;
      end else begin
         s_in = s_full[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= 1'b0;
         vp_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (en) begin
         vl_ff <= lg_valid;
         vp_ff <= vl_ff;
         ve_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sidel_ff <= lg_side;
         l_ff     <= l_in;
         sidep_ff <= sidel_ff;
         prod_ff  <= prod_in;
         sidee_ff <= sidep_ff;
         f_ff     <= f_in;
         s_ff     <= s_in;
      end
   end

   pt_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ve_ff),
      .in_side   (sidee_ff),
      .in_f      (f_ff),
      .in_s      (s_ff),
      .out_valid (ex_valid),
      .out_side  (ex_side),
      .out_r     (ex_r),
      .out_s     (ex_s)
   );

   assign acc_in  = 47'(ex_side.tk) * 47'(ex_r);
   assign rnd     = {1'b0, acc_ff} + (48'd1 << (sa_ff - 6'd1));
   assign shifted = rnd >> sa_ff;

   always_comb begin
      if (sidea_ff.miss) begin
         theta_in = '0;
      end else if (shifted > 48'(pt_pkg::ThetaMax)) begin
         theta_in = pt_pkg::ThetaMax;
      end else begin
         theta_in = shifted[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         va_ff        <= ex_valid;
         rsp_valid_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sidea_ff <= ex_side;
         acc_ff   <= acc_in;
         sa_ff    <= ex_s;
         theta_ff <= theta_in;
         miss_ff  <= sidea_ff.miss;
         last_ff  <= sidea_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_theta_kelvin   = theta_ff;
   assign rsp_result_missing = miss_ff;
   assign rsp_last_out       = last_ff;

endmodule

### rtl/core/pt_checker.sv
// Port-level checks for potential_temperature_unit, bound to the top level.
// Depends on potential_temperature_unit ports only.
module pt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [17:0] rsp_theta_kelvin,
   input logic        rsp_result_missing,
   input logic        rsp_last_out,
   input logic        pready
);

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_missing) |-> (rsp_theta_kelvin == 18'd0))
      else $error("missing result carries a value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_theta_kelvin)
         && $stable(rsp_result_missing) && $stable(rsp_last_out)))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_ready: assert property (@(posedge clock) pready)
      else $error("register port not ready");

endmodule

bind potential_temperature_unit pt_checker u_pt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_theta_kelvin   (rsp_theta_kelvin),
   .rsp_result_missing (rsp_result_missing),
   .rsp_last_out       (rsp_last_out),
   .pready             (pready)
);

### verif/tb_top.sv
// Self-checking bench for potential_temperature_unit: random and directed grid
// points with a bit-exact Poisson-equation predictor and APB kappa writes.
// Depends on pt_pkg and the potential_temperature_unit RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [2:0] KappaAddr = 3'd0;
   localparam logic [2:0] SpareAddr = 3'd4;

   typedef struct {
      logic signed [14:0] temp;
      logic               tmiss;
      logic [15:0]        pres;
      logic               pmiss;
      logic               last;
   } grid_point_type;

   typedef struct {
      logic [17:0] theta;
      logic        miss;
      logic        last;
   } theta_result_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [14:0] req_temp_celsius = '0;
   logic req_temp_missing = 0, req_pres_missing = 0, req_last_point = 0;
   logic [15:0] req_pressure_mb = '0;
   logic rsp_valid, rsp_stall = 0;
   logic [17:0] rsp_theta_kelvin;
   logic rsp_result_missing, rsp_last_out;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;

   potential_temperature_unit dut (.*);

   theta_result_type pending_theta[$];
   logic [15:0] model_kappa = pt_pkg::KappaReset;
   int errors = 0;
   int send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;

   initial forever #4 clock = ~clock;

   function automatic longint log2_q16(input longint unsigned x);
      int e;
      longint unsigned m;
      longint frac;
      e = 15;
      frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = x << (30 - e);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(e) * 65536 + frac;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic theta_result_type predict_theta(input grid_point_type p);
      theta_result_type o;
      longint tk, lg, ex, ei, s;
      longint unsigned r, c, acc;
      logic [15:0] f;
      o.theta = '0;
      o.miss = 1'b1;
      o.last = p.last;
      if (!p.tmiss && !p.pmiss && p.pres != 0) begin
         tk = longint'(p.temp) + 17482;
         lg = log2_q16(16000) - log2_q16(p.pres);
         ex = (lg * longint'(model_kappa) + 32768) >>> 16;
         ei = ex >>> 16;
         f = ex[15:0];
         r = 64'd1 << 30;
         c = 64'd1 << 31;
         for (int b = 15; b >= 0; b--) begin
            c = int_sqrt(c << 30);
            if (f[b]) r = (r * c) >> 30;
         end
         s = 30 - ei;
         if (s < 1) s = 1;
         if (s > 62) s = 62;
         acc = (longint'(tk) * r + (64'd1 << (s - 1))) >> s;
         o.theta = (acc > 262143) ? 18'h3FFFF : acc[17:0];
         o.miss = 1'b0;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      theta_result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_theta.size() == 0) begin
            report_mismatch("unexpected request result", rsp_theta_kelvin, -1);
         end else begin
            w = pending_theta.pop_front();
            if (rsp_theta_kelvin !== w.theta) report_mismatch("theta", rsp_theta_kelvin, w.theta);
            if (rsp_result_missing !== w.miss) report_mismatch("missing", rsp_result_missing, w.miss);
            if (rsp_last_out !== w.last) report_mismatch("last", rsp_last_out, w.last);
         end
      end
   end

   task automatic send_point(input grid_point_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temp_celsius <= p.temp;
      req_temp_missing <= p.tmiss;
      req_pressure_mb <= p.pres;
      req_pres_missing <= p.pmiss;
      req_last_point <= p.last;
      do @(posedge clock); while (req_stall);
      pending_theta.push_back(predict_theta(p));
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      go_idle();
      while (pending_theta.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_kappa(input logic [15:0] k);
      logic [31:0] rd;
      csr_access(1'b1, KappaAddr, {16'd0, k}, rd);
      model_kappa = k;
      csr_access(1'b0, KappaAddr, '0, rd);
      if (rd[15:0] !== k) report_mismatch("kappa readback", rd[15:0], k);
   endtask

   function automatic grid_point_type point(input int t, input int pr, input bit tm,
                                            input bit pm, input bit l);
      grid_point_type p;
      p.temp = 15'(t);
      p.pres = 16'(pr);
      p.tmiss = tm;
      p.pmiss = pm;
      p.last = l;
      return p;
   endfunction

   function automatic grid_point_type random_point();
      grid_point_type p;
      int sel;
      sel = $urandom_range(99);
      p.temp = 15'($urandom);
      p.tmiss = (sel < 5);
      p.pmiss = (sel >= 5 && sel < 10);
      case ($urandom_range(3))
         0: p.pres = 16'($urandom);
         1: p.pres = 16'($urandom_range(100, 20000));
         2: p.pres = 16'($urandom_range(1, 64));
         default: p.pres = (sel < 15) ? 16'd0 : 16'($urandom_range(40000, 65535));
      endcase
      p.last = ($urandom_range(15) == 0);
      return p;
   endfunction

   task automatic test_directed();
      int temps[3] = '{-16384, 16383, 0};
      int press[5] = '{1, 16000, 65535, 0, 32768};
      foreach (temps[i]) foreach (press[j]) send_point(point(temps[i], press[j], 0, 0, j == 4));
      send_point(point(100, 16000, 1, 0, 0));
      send_point(point(100, 16000, 0, 1, 1));
      send_point(point(-1, 0, 1, 1, 0));
      drain();
   endtask

   task automatic test_kappa_settings();
      logic [15:0] ks[4] = '{16'd0, 16'hFFFF, 16'h8000, 16'h5555};
      logic [31:0] rd;
      foreach (ks[i]) begin
         set_kappa(ks[i]);
         send_point(point(-16384, 1, 0, 0, 0));
         send_point(point(16383, 1, 0, 0, 0));
         send_point(point(16383, 65535, 0, 0, 1));
         send_point(point(-5000, 0, 0, 0, 0));
         repeat (20) send_point(random_point());
         drain();
      end
      // write above the only register leaves kappa untouched
      csr_access(1'b1, SpareAddr, 32'hFFFF_FFFF, rd);
      csr_access(1'b0, KappaAddr, '0, rd);
      if (rd[15:0] !== model_kappa) report_mismatch("kappa after spare write", rd[15:0], model_kappa);
      set_kappa(pt_pkg::KappaReset);
   endtask

   task automatic test_random_traffic();
      int pcts[3][2] = '{'{17, 56}, '{56, 17}, '{0, 0}};
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = pcts[ph][0];
         recv_idle_pct = pcts[ph][1];
         for (int i = 0; i < 220; i++) send_point(random_point());
         drain();
         set_kappa(16'($urandom));
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 300;
      for (int i = 0; i < 120; i++) send_point(random_point());
      drain();
      recv_idle_pct = 30;
      for (int i = 0; i < 40; i++) send_point(random_point());
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_kappa_settings();
      test_random_traffic();
      test_backpressure();
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("tb_top failed");
      $finish;
   end

endmodule

### potential_temperature_unit.f
rtl/core/pt_pkg.sv
rtl/core/pt_log2.sv
rtl/core/pt_exp2.sv
rtl/core/potential_temperature_unit.sv
rtl/core/pt_checker.sv
verif/tb_top.sv
